### sv/lcdseq_pkg.sv
package lcdseq_pkg;

	// register indexes on the configuration port
	localparam logic REG_INIT_CONTRAST    = 1'b0;
	localparam logic REG_POWER_WAIT_TICKS = 1'b1;

	// register reset values
	localparam logic [5:0] CONTRAST_RESET = 6'd35;
	localparam logic [7:0] WAIT_RESET     = 8'd50;

	// item function codes
	typedef enum logic [2:0] {
		FN_TICK     = 3'd0,
		FN_CURSOR   = 3'd1,
		FN_CONTRAST = 3'd2,
		FN_CHAR     = 3'd3,
		FN_RESTART  = 3'd4
	} func_t;

	// control bytes that open a transfer
	localparam logic [7:0] CTRL_CMD  = 8'h00;
	localparam logic [7:0] CTRL_DATA = 8'h41;

	// controller commands
	localparam logic [7:0] CMD_FUNC_SET    = 8'h38;
	localparam logic [7:0] CMD_FUNC_EXT    = 8'h39;
	localparam logic [7:0] CMD_ENTRY       = 8'h04;
	localparam logic [7:0] CMD_OSC         = 8'h14;
	localparam logic [7:0] CMD_CONTRAST_LO = 8'h70;
	localparam logic [7:0] CMD_CONTRAST_HI = 8'h5c;
	localparam logic [7:0] CMD_FOLLOWER    = 8'h6c;
	localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0c;
	localparam logic [7:0] CMD_CLEAR       = 8'h01;
	localparam logic [7:0] CMD_DDRAM       = 8'h80;

	// longest job in words, and the width of the word counter
	localparam int JOB_LEN_MAX = 14;
	localparam int IDX_W       = $clog2(JOB_LEN_MAX);

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// jobs handed from the front to the back
	typedef enum logic [2:0] {
		JOB_STATUS   = 3'd0,
		JOB_INIT1    = 3'd1,
		JOB_INIT2    = 3'd2,
		JOB_CURSOR   = 3'd3,
		JOB_CONTRAST = 3'd4,
		JOB_CHAR     = 3'd5
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic [7:0] arg;    // contrast, cursor address or character
		logic       first;
		logic       lastc;
		logic       ready;
	} job_t;

	// queue handshake between the modules
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// power-up sequence state
	typedef enum logic [3:0] {
		PH_START = 4'b0001,
		PH_WAIT  = 4'b0010,
		PH_FINAL = 4'b0100,
		PH_READY = 4'b1000
	} phase_t;

	// number of words a job sends
	function automatic logic [IDX_W-1:0] job_len(job_kind_t kind, logic first);
		logic [IDX_W-1:0] n;
		n = IDX_W'(1);
		case (kind)
			JOB_INIT1:    n = IDX_W'(14);
			JOB_INIT2:    n = IDX_W'(6);
			JOB_CURSOR:   n = IDX_W'(2);
			JOB_CONTRAST: n = IDX_W'(8);
			JOB_CHAR:     n = first ? IDX_W'(2) : IDX_W'(1);
			default:      n = IDX_W'(1);
		endcase
		return n;
	endfunction

	// command byte number num of a command job
	function automatic logic [7:0] cmd_byte(job_kind_t kind, logic [2:0] num,
			logic [7:0] arg);
		logic [7:0] b;
		b = CMD_FUNC_SET;
		case (kind)
			JOB_INIT1: begin
				case (num)
					3'd0:    b = CMD_FUNC_SET;
					3'd1:    b = CMD_FUNC_EXT;
					3'd2:    b = CMD_ENTRY;
					3'd3:    b = CMD_OSC;
					3'd4:    b = CMD_CONTRAST_LO | {4'h0, arg[3:0]};
					3'd5:    b = CMD_CONTRAST_HI | {6'h00, arg[5:4]};
					default: b = CMD_FOLLOWER;
				endcase
			end
			JOB_INIT2: begin
				case (num)
					3'd0:    b = CMD_FUNC_SET;
					3'd1:    b = CMD_DISPLAY_ON;
					default: b = CMD_CLEAR;
				endcase
			end
			JOB_CONTRAST: begin
				case (num)
					3'd0:    b = CMD_FUNC_EXT;
					3'd1:    b = CMD_CONTRAST_LO | {4'h0, arg[3:0]};
					3'd2:    b = CMD_CONTRAST_HI | {6'h00, arg[5:4]};
					default: b = CMD_FUNC_SET;
				endcase
			end
			JOB_CURSOR: b = CMD_DDRAM | arg;
			default:    b = arg;
		endcase
		return b;
	endfunction

endpackage

### sv/lcdseq_intf.sv
// input items
interface lcdseq_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic [5:0] column;
	logic       row;
	logic [5:0] contrast_value;
	logic [7:0] character;
	logic       first_char;
	logic       last_char;

	modport source (output valid, func, column, row, contrast_value, character,
		first_char, last_char, input ready);
	modport sink (input valid, func, column, row, contrast_value, character,
		first_char, last_char, output ready);
endinterface

// bus words out
interface lcdseq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] bus_byte;
	logic       byte_valid;
	logic       starts_transfer;
	logic       ends_transfer;
	logic       lcd_ready;
	logic       last;

	modport source (output valid, bus_byte, byte_valid, starts_transfer,
		ends_transfer, lcd_ready, last, input ready);
	modport sink (input valid, bus_byte, byte_valid, starts_transfer,
		ends_transfer, lcd_ready, last, output ready);
endinterface

// register writes
interface lcdseq_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/lcdseq_front.sv
module lcdseq_front (
	input  logic                 clk,
	input  logic                 arst_n,
	lcdseq_in_if.sink            in_ch,
	lcdseq_cfg_if.sink           cfg,
	input  lcdseq_pkg::q_stat_t  q_stat,
	output logic                 push,
	output lcdseq_pkg::job_t     job
);

	logic [5:0]          init_contrast_q;
	logic [7:0]          power_wait_ticks_q;
	lcdseq_pkg::phase_t  phase_q;
	lcdseq_pkg::phase_t  phase_d;
	logic [7:0]          wait_count_q;
	logic [7:0]          wait_count_d;
	logic [7:0]          wait_inc;

	// configuration registers, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_contrast_q    <= lcdseq_pkg::CONTRAST_RESET;
			power_wait_ticks_q <= lcdseq_pkg::WAIT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				lcdseq_pkg::REG_INIT_CONTRAST:    init_contrast_q <= cfg.data[5:0];
				lcdseq_pkg::REG_POWER_WAIT_TICKS: power_wait_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// accept whenever the queue has room
	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && !q_stat.full;
	assign wait_inc    = wait_count_q + 8'd1;

	// classify the item and advance the power-up sequence
	always_comb begin
		phase_d      = phase_q;
		wait_count_d = wait_count_q;
		job.kind     = lcdseq_pkg::JOB_STATUS;
		job.arg      = in_ch.character;
		job.first    = in_ch.first_char;
		job.lastc    = in_ch.last_char;
		job.ready    = (phase_q == lcdseq_pkg::PH_READY);
		case (in_ch.func)
			lcdseq_pkg::FN_TICK: begin
				case (phase_q)
					lcdseq_pkg::PH_START: begin
						job.kind     = lcdseq_pkg::JOB_INIT1;
						job.arg      = {2'b00, init_contrast_q};
						phase_d      = lcdseq_pkg::PH_WAIT;
						wait_count_d = 8'd0;
					end
					lcdseq_pkg::PH_WAIT: begin
						if (wait_inc == power_wait_ticks_q) begin
							job.kind     = lcdseq_pkg::JOB_INIT2;
							phase_d      = lcdseq_pkg::PH_FINAL;
							wait_count_d = 8'd0;
						end else begin
							wait_count_d = wait_inc;
						end
					end
					lcdseq_pkg::PH_FINAL: phase_d = lcdseq_pkg::PH_READY;
					default: ;
				endcase
			end
			lcdseq_pkg::FN_CURSOR: begin
				job.kind = lcdseq_pkg::JOB_CURSOR;
				job.arg  = {1'b0, in_ch.row, in_ch.column};
			end
			lcdseq_pkg::FN_CONTRAST: begin
				job.kind = lcdseq_pkg::JOB_CONTRAST;
				job.arg  = {2'b00, in_ch.contrast_value};
			end
			lcdseq_pkg::FN_CHAR: job.kind = lcdseq_pkg::JOB_CHAR;
			lcdseq_pkg::FN_RESTART: begin
				phase_d      = lcdseq_pkg::PH_START;
				wait_count_d = 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= lcdseq_pkg::PH_START;
			wait_count_q <= 8'd0;
		end else if (push) begin
			phase_q      <= phase_d;
			wait_count_q <= wait_count_d;
		end
	end

endmodule

### sv/lcdseq_queue.sv
module lcdseq_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  lcdseq_pkg::job_t     wdata,
	input  logic                 pop,
	output lcdseq_pkg::q_stat_t  q_stat,
	output lcdseq_pkg::job_t     head
);

	lcdseq_pkg::job_t                  mem_q [lcdseq_pkg::QUEUE_DEPTH];
	logic [lcdseq_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [lcdseq_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [lcdseq_pkg::QCNT_W-1:0]     count_q;

	assign q_stat.full  = (count_q == lcdseq_pkg::QCNT_W'(lcdseq_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign head         = mem_q[rd_ptr_q];

	// job storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: ;
			endcase
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= lcdseq_pkg::QCNT_W'(lcdseq_pkg::QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue popped while empty");
`endif

endmodule

### sv/lcdseq_back.sv
module lcdseq_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lcdseq_pkg::q_stat_t  q_stat,
	input  lcdseq_pkg::job_t     head,
	output logic                 pop,
	lcdseq_out_if.source         out_ch
);

	logic [lcdseq_pkg::IDX_W-1:0] idx_q;
	logic [lcdseq_pkg::IDX_W-1:0] len;
	logic                         advance;
	logic                         last_w;
	logic [7:0]                   byte_w;
	logic                         bvalid_w;
	logic                         st_w;
	logic                         en_w;
	logic                         valid_q;
	logic [7:0]                   byte_q;
	logic                         bvalid_q;
	logic                         st_q;
	logic                         en_q;
	logic                         ready_q;
	logic                         last_q;

	assign len     = lcdseq_pkg::job_len(head.kind, head.first);
	assign last_w  = (idx_q == len - 1'b1);
	assign advance = !q_stat.empty && (!valid_q || out_ch.ready);
	assign pop     = advance && last_w;

	// word idx_q of the job at the head of the queue
	always_comb begin
		byte_w   = lcdseq_pkg::CTRL_CMD;
		bvalid_w = 1'b1;
		st_w     = !idx_q[0];
		en_w     = idx_q[0];
		case (head.kind)
			lcdseq_pkg::JOB_STATUS: begin
				bvalid_w = 1'b0;
				st_w     = 1'b0;
				en_w     = 1'b0;
			end
			lcdseq_pkg::JOB_CHAR: begin
				if (head.first && idx_q == '0) begin
					byte_w = lcdseq_pkg::CTRL_DATA;
					st_w   = 1'b1;
					en_w   = 1'b0;
				end else begin
					byte_w = head.arg;
					st_w   = 1'b0;
					en_w   = head.lastc;
				end
			end
			default: begin
				// commands: control word on even, command on odd
				if (idx_q[0]) begin
					byte_w = lcdseq_pkg::cmd_byte(head.kind, idx_q[3:1], head.arg);
				end
			end
		endcase
	end

	// word counter within the job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (advance) begin
			idx_q <= last_w ? '0 : idx_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q   <= byte_w;
			bvalid_q <= bvalid_w;
			st_q     <= st_w;
			en_q     <= en_w;
			ready_q  <= head.ready;
			last_q   <= last_w;
		end
	end

	assign out_ch.valid           = valid_q;
	assign out_ch.bus_byte        = byte_q;
	assign out_ch.byte_valid      = bvalid_q;
	assign out_ch.starts_transfer = st_q;
	assign out_ch.ends_transfer   = en_q;
	assign out_ch.lcd_ready       = ready_q;
	assign out_ch.last            = last_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("word counter not cleared after job end");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !bvalid_q |-> last_q && !st_q && !en_q)
		else $error("status word malformed");
`endif

endmodule

### sv/i2c_character_lcd_command_sequencer.sv
// channel   dir  words                         handshake
// in_ch     in   func, cursor, contrast, char  valid/ready
// out_ch    out  one bus word per cycle if ready valid/ready
// cfg       in   index, data                    valid/ready, always ready
//
// An item is taken and queued; the back end sends its words at one per cycle
// while out_ch is ready; an item is 1 to 14 words (14 for JOB_INIT1).
// The output word counter in the back end sets the sustained rate.
// A two-entry job queue lets new items be taken while words still go out.
// arst_n clears the sequence state, queue and output valid; registers reset
// to contrast 35 and a wait of 50 ticks.
module i2c_character_lcd_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	lcdseq_in_if.sink   in_ch,
	lcdseq_out_if.source out_ch,
	lcdseq_cfg_if.sink  cfg
);

	lcdseq_pkg::q_stat_t q_stat;
	lcdseq_pkg::job_t    job;
	lcdseq_pkg::job_t    head;
	logic                push;
	logic                pop;

	lcdseq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.cfg    (cfg),
		.q_stat (q_stat),
		.push   (push),
		.job    (job)
	);

	lcdseq_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (job),
		.pop    (pop),
		.q_stat (q_stat),
		.head   (head)
	);

	lcdseq_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

### verif/tb_i2c_character_lcd_command_sequencer.sv
module tb_i2c_character_lcd_command_sequencer;

	// controller commands and control bytes
	localparam logic [7:0] LCD_CTRL_CMD   = 8'h00;
	localparam logic [7:0] LCD_CTRL_DATA  = 8'h41;
	localparam logic [7:0] LCD_FUNC_SET   = 8'h38;
	localparam logic [7:0] LCD_FUNC_EXT   = 8'h39;
	localparam logic [7:0] LCD_ENTRY_MODE = 8'h04;
	localparam logic [7:0] LCD_OSC_FREQ   = 8'h14;
	localparam logic [7:0] LCD_CONTR_LO   = 8'h70;
	localparam logic [7:0] LCD_CONTR_HI   = 8'h5c;
	localparam logic [7:0] LCD_FOLLOWER   = 8'h6c;
	localparam logic [7:0] LCD_DISP_ON    = 8'h0c;
	localparam logic [7:0] LCD_CLEAR      = 8'h01;
	localparam logic [7:0] LCD_SET_DDRAM  = 8'h80;

	// func codes that the block does not use
	localparam logic [2:0] FN_SPARE_LO = 3'd5;
	localparam logic [2:0] FN_SPARE_HI = 3'd7;

	typedef enum int {SEQ_IDLE, SEQ_WAIT, SEQ_FINAL, SEQ_READY} seq_phase_t;

	typedef struct packed {
		logic [2:0] func;
		logic [5:0] column;
		logic       row;
		logic [5:0] cval;
		logic [7:0] character;
		logic       first_char;
		logic       last_char;
	} lcd_item_t;

	typedef struct packed {
		logic [7:0] bus_byte;
		logic       byte_valid;
		logic       starts;
		logic       ends;
		logic       lcd_rdy;
		logic       last;
	} lcd_word_t;

	logic clk = 1'b0;
	logic arst_n;

	lcdseq_in_if  in_ch();
	lcdseq_out_if out_ch();
	lcdseq_cfg_if cfg();

	i2c_character_lcd_command_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state and register copies
	seq_phase_t seq_phase    = SEQ_IDLE;
	logic [7:0] tick_count   = 8'd0;
	logic [5:0] contrast_reg = 6'd35;
	logic [7:0] wait_reg     = 8'd50;
	logic       word_rdy;

	lcd_word_t bus_words_exp[$];
	lcd_word_t staged[$];

	int tx_gap_max = 5;
	int rx_gap_max = 5;
	int rx_hold    = 0;
	int err_count  = 0;
	int n_items    = 0;
	int n_words    = 0;
	int n_status   = 0;
	int n_writes   = 0;

	function automatic void stage_word(input logic [7:0] b, input logic v,
			input logic st, input logic en);
		lcd_word_t w;
		w.bus_byte   = b;
		w.byte_valid = v;
		w.starts     = st;
		w.ends       = en;
		w.lcd_rdy    = word_rdy;
		w.last       = 1'b0;
		staged.push_back(w);
	endfunction

	// a command is its own transfer: control byte, then the command
	function automatic void stage_cmd(input logic [7:0] cmd);
		stage_word(LCD_CTRL_CMD, 1'b1, 1'b1, 1'b0);
		stage_word(cmd, 1'b1, 1'b0, 1'b1);
	endfunction

	function automatic void stage_contrast(input logic [5:0] c);
		stage_cmd(LCD_CONTR_LO | {4'h0, c[3:0]});
		stage_cmd(LCD_CONTR_HI | {6'h00, c[5:4]});
	endfunction

	// bus words that one accepted item produces
	function automatic void predict_bus_words(input lcd_item_t it);
		lcd_word_t w;
		int i;
		word_rdy = (seq_phase == SEQ_READY);
		staged.delete();
		case (it.func)
			lcdseq_pkg::FN_TICK: begin
				case (seq_phase)
					SEQ_IDLE: begin
						stage_cmd(LCD_FUNC_SET);
						stage_cmd(LCD_FUNC_EXT);
						stage_cmd(LCD_ENTRY_MODE);
						stage_cmd(LCD_OSC_FREQ);
						stage_contrast(contrast_reg);
						stage_cmd(LCD_FOLLOWER);
						seq_phase  = SEQ_WAIT;
						tick_count = 8'd0;
					end
					SEQ_WAIT: begin
						// 8-bit count wraps, so a wait of zero means 256 ticks
						tick_count = tick_count + 8'd1;
						if (tick_count == wait_reg) begin
							stage_cmd(LCD_FUNC_SET);
							stage_cmd(LCD_DISP_ON);
							stage_cmd(LCD_CLEAR);
							seq_phase  = SEQ_FINAL;
							tick_count = 8'd0;
						end
					end
					SEQ_FINAL: seq_phase = SEQ_READY;
					default: ;
				endcase
			end
			lcdseq_pkg::FN_CURSOR: stage_cmd(LCD_SET_DDRAM | {1'b0, it.row, it.column});
			lcdseq_pkg::FN_CONTRAST: begin
				stage_cmd(LCD_FUNC_EXT);
				stage_contrast(it.cval);
				stage_cmd(LCD_FUNC_SET);
			end
			lcdseq_pkg::FN_CHAR: begin
				if (it.first_char)
					stage_word(LCD_CTRL_DATA, 1'b1, 1'b1, 1'b0);
				stage_word(it.character, 1'b1, 1'b0, it.last_char);
			end
			lcdseq_pkg::FN_RESTART: begin
				seq_phase  = SEQ_IDLE;
				tick_count = 8'd0;
			end
			default: ;
		endcase
		if (staged.size() == 0)
			stage_word(8'h00, 1'b0, 1'b0, 1'b0);
		for (i = 0; i < staged.size(); i++) begin
			w = staged[i];
			w.last = (i == staged.size() - 1);
			bus_words_exp.push_back(w);
		end
	endfunction

	// compare one accepted bus word with the oldest expectation
	task automatic check_bus_word();
		lcd_word_t want;
		n_words++;
		if (!out_ch.byte_valid)
			n_status++;
		if (bus_words_exp.size() == 0) begin
			$error("unexpected bus word: bus_byte %02h", out_ch.bus_byte);
			err_count++;
		end else begin
			want = bus_words_exp.pop_front();
			if (out_ch.bus_byte !== want.bus_byte) begin
				$error("bus_byte: expected %02h, got %02h", want.bus_byte, out_ch.bus_byte);
				err_count++;
			end
			if (out_ch.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %0b, got %0b", want.byte_valid,
					out_ch.byte_valid);
				err_count++;
			end
			if (out_ch.starts_transfer !== want.starts) begin
				$error("starts_transfer: expected %0b, got %0b", want.starts,
					out_ch.starts_transfer);
				err_count++;
			end
			if (out_ch.ends_transfer !== want.ends) begin
				$error("ends_transfer: expected %0b, got %0b", want.ends,
					out_ch.ends_transfer);
				err_count++;
			end
			if (out_ch.lcd_ready !== want.lcd_rdy) begin
				$error("lcd_ready: expected %0b, got %0b", want.lcd_rdy, out_ch.lcd_ready);
				err_count++;
			end
			if (out_ch.last !== want.last) begin
				$error("last: expected %0b, got %0b", want.last, out_ch.last);
				err_count++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			check_bus_word();
	end

	// receiver: random stall per word, plus an optional long hold-off
	initial begin
		int gap;
		int n;
		out_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			gap = $urandom_range(0, rx_gap_max);
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// sender: leaves valid high on return, the next call or a drain decides
	task automatic send_item(input lcd_item_t it);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid          <= 1'b1;
		in_ch.func           <= it.func;
		in_ch.column         <= it.column;
		in_ch.row            <= it.row;
		in_ch.contrast_value <= it.cval;
		in_ch.character      <= it.character;
		in_ch.first_char     <= it.first_char;
		in_ch.last_char      <= it.last_char;
		do @(posedge clk); while (!in_ch.ready);
		predict_bus_words(it);
		n_items++;
	endtask

	// unused fields carry random junk
	function automatic lcd_item_t rand_item(input logic [2:0] f);
		lcd_item_t it;
		it = lcd_item_t'($urandom);
		it.func = f;
		return it;
	endfunction

	task automatic send_func(input logic [2:0] f);
		send_item(rand_item(f));
	endtask

	task automatic send_ticks(input int n);
		repeat (n) send_func(lcdseq_pkg::FN_TICK);
	endtask

	task automatic send_cursor(input logic [5:0] col, input logic r);
		lcd_item_t it;
		it = rand_item(lcdseq_pkg::FN_CURSOR);
		it.column = col;
		it.row    = r;
		send_item(it);
	endtask

	task automatic send_contrast(input logic [5:0] v);
		lcd_item_t it;
		it = rand_item(lcdseq_pkg::FN_CONTRAST);
		it.cval = v;
		send_item(it);
	endtask

	task automatic send_char(input logic [7:0] ch, input logic f, input logic l);
		lcd_item_t it;
		it = rand_item(lcdseq_pkg::FN_CHAR);
		it.character  = ch;
		it.first_char = f;
		it.last_char  = l;
		send_item(it);
	endtask

	// stop offering and wait for every expected word
	task automatic drain_words();
		in_ch.valid <= 1'b0;
		while (bus_words_exp.size() != 0) @(posedge clk);
	endtask

	// both registers back to back, only while the block is idle
	task automatic write_regs(input logic [7:0] contrast_data, input logic [7:0] wait_data);
		cfg.valid <= 1'b1;
		cfg.index <= lcdseq_pkg::REG_INIT_CONTRAST;
		cfg.data  <= contrast_data;
		do @(posedge clk); while (!cfg.ready);
		contrast_reg = contrast_data[5:0];
		cfg.index <= lcdseq_pkg::REG_POWER_WAIT_TICKS;
		cfg.data  <= wait_data;
		do @(posedge clk); while (!cfg.ready);
		wait_reg = wait_data;
		cfg.valid <= 1'b0;
		n_writes += 2;
	endtask

	// power-up with reset register values, items before ready
	task automatic test_power_up_defaults();
		send_char(8'h55, 1'b1, 1'b1);
		send_func(FN_SPARE_HI);
		send_func(lcdseq_pkg::FN_RESTART);
		send_ticks(1);
		send_ticks(50);
		send_ticks(1);
		send_cursor(6'd5, 1'b1);
		drain_words();
	endtask

	// every operation at its extremes once the display is ready
	task automatic test_directed_ops();
		logic [2:0] f;
		send_cursor(6'd0, 1'b0);
		send_cursor(6'd63, 1'b0);
		send_cursor(6'd0, 1'b1);
		send_cursor(6'd63, 1'b1);
		send_contrast(6'd0);
		send_contrast(6'd63);
		send_contrast(6'h15);
		send_contrast(6'h2a);
		// strings, and stray characters with no string open
		send_char(8'h00, 1'b1, 1'b0);
		send_char(8'hff, 1'b0, 1'b0);
		send_char(8'ha5, 1'b0, 1'b1);
		send_char(8'h5a, 1'b1, 1'b1);
		send_char(8'h3c, 1'b0, 1'b1);
		for (f = FN_SPARE_LO; f <= FN_SPARE_HI && f >= FN_SPARE_LO; f++)
			send_func(f);
		send_ticks(1);
		// restart while ready, then the set-up group again
		send_func(lcdseq_pkg::FN_RESTART);
		send_ticks(1);
		send_func(lcdseq_pkg::FN_RESTART);
		drain_words();
	endtask

	// register extremes and a wait changed half way
	task automatic test_register_extremes();
		write_regs(8'h00, 8'd1);
		send_ticks(3);
		send_cursor(6'd17, 1'b0);
		drain_words();
		write_regs(8'hff, 8'd255);
		send_func(lcdseq_pkg::FN_RESTART);
		send_ticks(5);
		drain_words();
		write_regs(8'hea, 8'd6);
		send_ticks(3);
		send_char(8'h41, 1'b1, 1'b1);
		drain_words();
	endtask

	// a wait of zero runs the full 256 ticks
	task automatic test_wait_zero();
		tx_gap_max = 0;
		rx_gap_max = 0;
		write_regs(8'($urandom), 8'd0);
		send_func(lcdseq_pkg::FN_RESTART);
		send_ticks(258);
		send_cursor(6'd9, 1'b1);
		drain_words();
		tx_gap_max = 5;
		rx_gap_max = 5;
	endtask

	// long receiver hold-off while the sender keeps offering
	task automatic test_backpressure();
		tx_gap_max = 0;
		rx_hold = 120;
		repeat (12) send_func(lcdseq_pkg::FN_CONTRAST);
		send_ticks(2);
		drain_words();
		tx_gap_max = 5;
	endtask

	// random traffic in phases, register settings changed between them
	task automatic test_random_traffic();
		int ph;
		int sent;
		int r;
		int len;
		int k;
		for (ph = 0; ph < 2; ph++) begin
			drain_words();
			write_regs(8'($urandom), 8'($urandom_range(1, 6)));
			tx_gap_max = (ph == 1) ? 0 : 5;
			rx_gap_max = (ph == 1) ? 0 : 5;
			sent = 0;
			while (sent < 10) begin
				r = $urandom_range(0, 99);
				if (r < 30) begin
					send_func(lcdseq_pkg::FN_TICK);
					sent++;
				end else if (r < 45) begin
					send_func(lcdseq_pkg::FN_CURSOR);
					sent++;
				end else if (r < 55) begin
					send_func(lcdseq_pkg::FN_CONTRAST);
					sent++;
				end else if (r < 85) begin
					len = $urandom_range(1, 5);
					for (k = 0; k < len; k++)
						send_char(8'($urandom), k == 0, k == len - 1);
					sent += len;
				end else if (r < 90) begin
					send_func(lcdseq_pkg::FN_CHAR);
					sent++;
				end else if (r < 94) begin
					send_func(lcdseq_pkg::FN_RESTART);
					sent++;
				end else begin
					send_func(3'($urandom_range(FN_SPARE_LO, FN_SPARE_HI)));
					sent++;
				end
			end
		end
		drain_words();
		tx_gap_max = 5;
		rx_gap_max = 5;
	endtask

	initial begin
		arst_n               <= 1'b0;
		in_ch.valid          <= 1'b0;
		in_ch.func           <= lcdseq_pkg::FN_TICK;
		in_ch.column         <= 6'd0;
		in_ch.row            <= 1'b0;
		in_ch.contrast_value <= 6'd0;
		in_ch.character      <= 8'h00;
		in_ch.first_char     <= 1'b0;
		in_ch.last_char      <= 1'b0;
		cfg.valid            <= 1'b0;
		cfg.index            <= lcdseq_pkg::REG_INIT_CONTRAST;
		cfg.data             <= 8'h00;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_power_up_defaults();
		test_directed_ops();
		test_register_extremes();
		test_wait_zero();
		test_backpressure();
		test_random_traffic();

		// catch any stray words after the last expectation
		repeat (30) @(posedge clk);
		$display("Run: %0d items, %0d bus words (%0d status), %0d register writes",
			n_items, n_words, n_status, n_writes);
		$display("Covered power-up incl. zero wait, cursor, contrast, strings, restart, spare codes");
		if (err_count == 0)
			$display("PASS i2c_character_lcd_command_sequencer");
		else
			$display("FAIL i2c_character_lcd_command_sequencer");
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("FAIL i2c_character_lcd_command_sequencer");
		$finish;
	end

endmodule

### sim.f
sv/lcdseq_pkg.sv
sv/lcdseq_intf.sv
sv/lcdseq_front.sv
sv/lcdseq_queue.sv
sv/lcdseq_back.sv
sv/i2c_character_lcd_command_sequencer.sv
verif/tb_i2c_character_lcd_command_sequencer.sv
